FILE: sv/lca_pkg.sv
`default_nettype none
package lca_pkg;

	localparam int MAX_NODES   = 1024;
	localparam int LIFT_LEVELS = 10;

	localparam int NODE_W      = 10;
	localparam int EDGE_W      = 12;
	localparam int DEPTH_W     = 11;
	localparam int LEN_W       = 11;
	localparam int STAT_W      = 2;
	localparam int EDGE_SLOTS  = 2 * MAX_NODES;
	localparam int NODE_AW     = $clog2(MAX_NODES);
	localparam int SLOT_AW     = $clog2(EDGE_SLOTS);
	localparam int ANC_DEPTH   = MAX_NODES * LIFT_LEVELS;
	localparam int ANC_AW      = $clog2(ANC_DEPTH);
	localparam int LVL_W       = $clog2(LIFT_LEVELS + 1);
	localparam int SWP_W       = NODE_AW + 1;

	localparam logic [EDGE_W-1:0]  EDGE_NONE  = EDGE_W'(EDGE_SLOTS);
	localparam logic [DEPTH_W-1:0] DEPTH_NONE = '1;

	typedef enum logic [1:0] {
		KIND_CLEAR = 2'd0,
		KIND_ADD   = 2'd1,
		KIND_BUILD = 2'd2,
		KIND_QUERY = 2'd3
	} kind_t;

	localparam logic [STAT_W-1:0] STAT_OK        = 2'd0;
	localparam logic [STAT_W-1:0] STAT_BAD       = 2'd1;
	localparam logic [STAT_W-1:0] STAT_UNVISITED = 2'd2;

	function automatic logic good_node(input logic [NODE_W-1:0] n);
		return (n != '0) && ({1'b0, n} < (NODE_W + 1)'(MAX_NODES));
	endfunction

	function automatic logic [ANC_AW-1:0] anc_addr(input logic [NODE_W-1:0] n,
			input logic [LVL_W-1:0] lvl);
		return ANC_AW'(ANC_AW'(n) * ANC_AW'(LIFT_LEVELS)) + ANC_AW'(lvl);
	endfunction

endpackage
`default_nettype wire

FILE: sv/tree_lca_binary_lifting_core.sv
// channel   dir  handshake                     payload (low bit first)
// s_axis    in   s_axis_tvalid/s_axis_tready   tdata: node_a, node_b; tuser: kind
// m_axis    out  m_axis_tvalid/m_axis_tready   tdata: ancestor, path_length; tuser: status
// cfg       in   cfg_valid/cfg_ready           cfg_data: root_node
//
// One item at a time. Query: one pass per lift level plus one per joint level,
// bound by the single read port of the ancestor table.
// Clear: sweep of the head and depth memories. Build: a sweep of the depth memory only,
// then seeding of the root, then work per popped node, per stored edge, and per ancestor
// level for each newly reached node. After reset the clear sweep runs before the first beat.
// A result waits in the output register; the next beat is taken meanwhile, and its
// result holds in ST_RESP until the register is free.
`default_nettype none
module tree_lca_binary_lifting_core
	import lca_pkg::*;
(
	input  wire logic        clk,
	input  wire logic        arst_n,
	input  wire logic        s_axis_tvalid,
	output logic             s_axis_tready,
	input  wire logic [23:0] s_axis_tdata,   // node_a[9:0], node_b[19:10]
	input  wire logic [1:0]  s_axis_tuser,   // kind[1:0]
	output logic             m_axis_tvalid,
	input  wire logic        m_axis_tready,
	output logic      [23:0] m_axis_tdata,   // ancestor[9:0], path_length[20:10]
	output logic      [1:0]  m_axis_tuser,   // status[1:0]
	input  wire logic        cfg_valid,
	output logic             cfg_ready,
	input  wire logic [9:0]  cfg_data        // root_node
);

	typedef enum logic [30:0] {
		ST_SWEEP  = 31'h1 << 0,
		ST_IDLE   = 31'h1 << 1,
		ST_RESP   = 31'h1 << 2,
		ST_ADD_RA = 31'h1 << 3,
		ST_ADD_WA = 31'h1 << 4,
		ST_ADD_RB = 31'h1 << 5,
		ST_ADD_WB = 31'h1 << 6,
		ST_B_INIT = 31'h1 << 7,
		ST_B_POP  = 31'h1 << 8,
		ST_B_POPW = 31'h1 << 9,
		ST_B_HEAD = 31'h1 << 10,
		ST_B_EDGE = 31'h1 << 11,
		ST_B_TGT  = 31'h1 << 12,
		ST_B_CHK  = 31'h1 << 13,
		ST_B_LR   = 31'h1 << 14,
		ST_B_LW   = 31'h1 << 15,
		ST_Q_RA   = 31'h1 << 16,
		ST_Q_RB   = 31'h1 << 17,
		ST_Q_CHK  = 31'h1 << 18,
		ST_Q_LR   = 31'h1 << 19,
		ST_Q_LD   = 31'h1 << 20,
		ST_Q_LC   = 31'h1 << 21,
		ST_Q_SAME = 31'h1 << 22,
		ST_Q_JU   = 31'h1 << 23,
		ST_Q_JV   = 31'h1 << 24,
		ST_Q_JC   = 31'h1 << 25,
		ST_Q_PR   = 31'h1 << 26,
		ST_Q_PD   = 31'h1 << 27,
		ST_Q_DL   = 31'h1 << 28,
		ST_Q_DW   = 31'h1 << 29
	} state_t;

	typedef enum logic [1:0] {
		AFT_IDLE  = 2'd0,
		AFT_RESP  = 2'd1,
		AFT_BUILD = 2'd2
	} after_t;

	state_t state_q;
	after_t after_q;
	logic   heads_q;
	logic [SWP_W-1:0]   swp_q;
	logic [NODE_W-1:0]  root_q;
	logic [NODE_W-1:0]  a_q, b_q;
	logic [EDGE_W-1:0]  ecnt_q;
	logic [EDGE_W-1:0]  e_q, nx_q;
	logic [SWP_W-1:0]   qh_q, qt_q;
	logic [NODE_W-1:0]  u_q, v_q, j_q, cur_q, t_q, au_q;
	logic [DEPTH_W-1:0] du_q, da_q, db_q, dv_q;
	logic [LVL_W-1:0]   k_q;
	logic               m_valid_q;
	logic [NODE_W-1:0]  res_anc_q;
	logic [LEN_W-1:0]   res_len_q;
	logic [STAT_W-1:0]  res_st_q;
	logic [NODE_W-1:0]  out_anc_q;
	logic [LEN_W-1:0]   out_len_q;
	logic [STAT_W-1:0]  out_st_q;

	logic                head_we;
	logic [NODE_AW-1:0]  head_waddr, head_raddr;
	logic [EDGE_W-1:0]   head_wdata, head_rdata;
	logic                edge_we;
	logic [SLOT_AW-1:0]  edge_waddr, edge_raddr;
	logic [EDGE_W-1:0]   nxt_wdata, nxt_rdata;
	logic [NODE_W-1:0]   tgt_wdata, tgt_rdata;
	logic                dep_we;
	logic [NODE_AW-1:0]  dep_waddr, dep_raddr;
	logic [DEPTH_W-1:0]  dep_wdata, dep_rdata;
	logic                anc_we;
	logic [ANC_AW-1:0]   anc_waddr, anc_raddr;
	logic [NODE_W-1:0]   anc_wdata, anc_rdata;
	logic                q_we;
	logic [NODE_AW-1:0]  q_waddr, q_raddr;
	logic [NODE_W-1:0]   q_wdata, q_rdata;

	logic [NODE_W-1:0]   in_a, in_b, lift_x;
	kind_t               in_kind;
	logic                in_fire;
	logic [DEPTH_W-1:0]  du_inc;

	assign in_a    = s_axis_tdata[9:0];
	assign in_b    = s_axis_tdata[19:10];
	assign in_kind = kind_t'(s_axis_tuser);
	assign s_axis_tready = (state_q == ST_IDLE);
	assign in_fire = s_axis_tvalid && s_axis_tready;
	assign cfg_ready = 1'b1;
	assign du_inc = du_q + DEPTH_W'(1);
	assign lift_x = (cur_q == '0) ? '0 : anc_rdata;

	assign m_axis_tvalid = m_valid_q;
	assign m_axis_tdata  = {3'b000, out_len_q, out_anc_q};
	assign m_axis_tuser  = out_st_q;

	lca_ram #(.WIDTH(EDGE_W), .DEPTH(MAX_NODES)) u_head (
		.clk(clk), .we(head_we), .waddr(head_waddr), .wdata(head_wdata),
		.raddr(head_raddr), .rdata(head_rdata));
	lca_ram #(.WIDTH(EDGE_W), .DEPTH(EDGE_SLOTS)) u_next (
		.clk(clk), .we(edge_we), .waddr(edge_waddr), .wdata(nxt_wdata),
		.raddr(edge_raddr), .rdata(nxt_rdata));
	lca_ram #(.WIDTH(NODE_W), .DEPTH(EDGE_SLOTS)) u_target (
		.clk(clk), .we(edge_we), .waddr(edge_waddr), .wdata(tgt_wdata),
		.raddr(edge_raddr), .rdata(tgt_rdata));
	lca_ram #(.WIDTH(DEPTH_W), .DEPTH(MAX_NODES)) u_depth (
		.clk(clk), .we(dep_we), .waddr(dep_waddr), .wdata(dep_wdata),
		.raddr(dep_raddr), .rdata(dep_rdata));
	lca_ram #(.WIDTH(NODE_W), .DEPTH(ANC_DEPTH)) u_anc (
		.clk(clk), .we(anc_we), .waddr(anc_waddr), .wdata(anc_wdata),
		.raddr(anc_raddr), .rdata(anc_rdata));
	lca_ram #(.WIDTH(NODE_W), .DEPTH(MAX_NODES)) u_queue (
		.clk(clk), .we(q_we), .waddr(q_waddr), .wdata(q_wdata),
		.raddr(q_raddr), .rdata(q_rdata));

	always_comb begin
		head_we    = 1'b0;
		head_waddr = a_q[NODE_AW-1:0];
		head_wdata = ecnt_q;
		head_raddr = a_q[NODE_AW-1:0];
		edge_we    = 1'b0;
		edge_waddr = ecnt_q[SLOT_AW-1:0];
		edge_raddr = e_q[SLOT_AW-1:0];
		nxt_wdata  = head_rdata;
		tgt_wdata  = b_q;
		dep_we     = 1'b0;
		dep_waddr  = j_q[NODE_AW-1:0];
		dep_wdata  = du_inc;
		dep_raddr  = a_q[NODE_AW-1:0];
		anc_we     = 1'b0;
		anc_waddr  = anc_addr(j_q, k_q);
		anc_wdata  = lift_x;
		anc_raddr  = anc_addr(u_q, k_q);
		q_we       = 1'b0;
		q_waddr    = qt_q[NODE_AW-1:0];
		q_wdata    = j_q;
		q_raddr    = qh_q[NODE_AW-1:0];
		case (state_q)
			ST_SWEEP: begin
				head_we    = heads_q;
				head_waddr = swp_q[NODE_AW-1:0];
				head_wdata = EDGE_NONE;
				dep_we     = 1'b1;
				dep_waddr  = swp_q[NODE_AW-1:0];
				dep_wdata  = (swp_q == '0) ? '0 : DEPTH_NONE;
			end
			ST_ADD_WA: begin
				edge_we = 1'b1;
				head_we = 1'b1;
			end
			ST_ADD_RB: begin
				head_raddr = b_q[NODE_AW-1:0];
			end
			ST_ADD_WB: begin
				edge_we    = 1'b1;
				tgt_wdata  = a_q;
				head_we    = 1'b1;
				head_waddr = b_q[NODE_AW-1:0];
			end
			ST_B_INIT: begin
				anc_we    = 1'b1;
				anc_waddr = anc_addr(root_q, k_q);
				anc_wdata = '0;
				dep_we    = (k_q == '0);
				dep_waddr = root_q[NODE_AW-1:0];
				dep_wdata = DEPTH_W'(1);
				q_we      = (k_q == '0);
				q_waddr   = '0;
				q_wdata   = root_q;
			end
			ST_B_POPW: begin
				dep_raddr  = q_rdata[NODE_AW-1:0];
				head_raddr = q_rdata[NODE_AW-1:0];
			end
			ST_B_TGT: begin
				dep_raddr = tgt_rdata[NODE_AW-1:0];
			end
			ST_B_CHK: begin
				if (dep_rdata > du_inc) begin
					dep_we    = 1'b1;
					q_we      = (qt_q < SWP_W'(MAX_NODES));
					anc_we    = 1'b1;
					anc_waddr = anc_addr(j_q, '0);
					anc_wdata = u_q;
				end
			end
			ST_B_LR: begin
				anc_raddr = anc_addr(cur_q, k_q - LVL_W'(1));
			end
			ST_B_LW: begin
				anc_we = 1'b1;
			end
			ST_Q_RB: begin
				dep_raddr = b_q[NODE_AW-1:0];
			end
			ST_Q_LD: begin
				dep_raddr = anc_rdata[NODE_AW-1:0];
			end
			ST_Q_JV: begin
				anc_raddr = anc_addr(v_q, k_q);
			end
			ST_Q_PR: begin
				anc_raddr = anc_addr(u_q, '0);
			end
			ST_Q_DL: begin
				dep_raddr = res_anc_q[NODE_AW-1:0];
			end
			default: begin
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q   <= ST_SWEEP;
			after_q   <= AFT_IDLE;
			heads_q   <= 1'b1;
			swp_q     <= '0;
			root_q    <= NODE_W'(1);
			ecnt_q    <= '0;
			qh_q      <= '0;
			qt_q      <= '0;
			k_q       <= '0;
			m_valid_q <= 1'b0;
			out_anc_q <= '0;
			out_len_q <= '0;
			out_st_q  <= STAT_OK;
		end else begin
			if (cfg_valid && cfg_ready)
				root_q <= cfg_data;
			if (state_q == ST_RESP && (!m_valid_q || m_axis_tready))
				m_valid_q <= 1'b1;
			else if (m_valid_q && m_axis_tready)
				m_valid_q <= 1'b0;
			case (state_q)
				ST_SWEEP: begin
					swp_q <= swp_q + SWP_W'(1);
					if (swp_q == SWP_W'(MAX_NODES - 1)) begin
						if (heads_q)
							ecnt_q <= '0;
						k_q <= '0;
						case (after_q)
							AFT_RESP:  state_q <= ST_RESP;
							AFT_BUILD: state_q <= ST_B_INIT;
							default:   state_q <= ST_IDLE;
						endcase
					end
				end
				ST_IDLE: begin
					if (in_fire) begin
						a_q       <= in_a;
						b_q       <= in_b;
						res_anc_q <= '0;
						res_len_q <= '0;
						swp_q     <= '0;
						case (in_kind)
							KIND_CLEAR: begin
								res_st_q <= STAT_OK;
								heads_q  <= 1'b1;
								after_q  <= AFT_RESP;
								state_q  <= ST_SWEEP;
							end
							KIND_ADD: begin
								if (!good_node(in_a) || !good_node(in_b) ||
										((EDGE_W + 1)'(ecnt_q) + (EDGE_W + 1)'(2)) >
										(EDGE_W + 1)'(EDGE_SLOTS)) begin
									res_st_q <= STAT_BAD;
									state_q  <= ST_RESP;
								end else begin
									res_st_q <= STAT_OK;
									state_q  <= ST_ADD_RA;
								end
							end
							KIND_BUILD: begin
								if (!good_node(root_q)) begin
									res_st_q <= STAT_BAD;
									state_q  <= ST_RESP;
								end else begin
									res_st_q <= STAT_OK;
									heads_q  <= 1'b0;
									after_q  <= AFT_BUILD;
									state_q  <= ST_SWEEP;
								end
							end
							default: begin
								if (!good_node(in_a) || !good_node(in_b)) begin
									res_st_q <= STAT_BAD;
									state_q  <= ST_RESP;
								end else begin
									res_st_q <= STAT_OK;
									state_q  <= ST_Q_RA;
								end
							end
						endcase
					end
				end
				ST_RESP: begin
					if (!m_valid_q || m_axis_tready) begin
						out_anc_q <= res_anc_q;
						out_len_q <= res_len_q;
						out_st_q  <= res_st_q;
						state_q   <= ST_IDLE;
					end
				end
				ST_ADD_RA: state_q <= ST_ADD_WA;
				ST_ADD_WA: begin
					ecnt_q  <= ecnt_q + EDGE_W'(1);
					state_q <= ST_ADD_RB;
				end
				ST_ADD_RB: state_q <= ST_ADD_WB;
				ST_ADD_WB: begin
					ecnt_q  <= ecnt_q + EDGE_W'(1);
					state_q <= ST_RESP;
				end
				ST_B_INIT: begin
					k_q <= k_q + LVL_W'(1);
					if (k_q == LVL_W'(LIFT_LEVELS - 1)) begin
						qh_q    <= '0;
						qt_q    <= SWP_W'(1);
						state_q <= ST_B_POP;
					end
				end
				ST_B_POP: begin
					if (qh_q < qt_q) begin
						qh_q    <= qh_q + SWP_W'(1);
						state_q <= ST_B_POPW;
					end else begin
						state_q <= ST_RESP;
					end
				end
				ST_B_POPW: begin
					u_q     <= q_rdata;
					state_q <= ST_B_HEAD;
				end
				ST_B_HEAD: begin
					du_q    <= dep_rdata;
					e_q     <= head_rdata;
					state_q <= ST_B_EDGE;
				end
				ST_B_EDGE: begin
					state_q <= (e_q < ecnt_q) ? ST_B_TGT : ST_B_POP;
				end
				ST_B_TGT: begin
					j_q     <= tgt_rdata;
					nx_q    <= nxt_rdata;
					state_q <= ST_B_CHK;
				end
				ST_B_CHK: begin
					if (dep_rdata > du_inc) begin
						if (qt_q < SWP_W'(MAX_NODES))
							qt_q <= qt_q + SWP_W'(1);
						cur_q   <= u_q;
						k_q     <= LVL_W'(1);
						state_q <= ST_B_LR;
					end else begin
						e_q     <= nx_q;
						state_q <= ST_B_EDGE;
					end
				end
				ST_B_LR: begin
					if (k_q == LVL_W'(LIFT_LEVELS)) begin
						e_q     <= nx_q;
						state_q <= ST_B_EDGE;
					end else begin
						state_q <= ST_B_LW;
					end
				end
				ST_B_LW: begin
					cur_q   <= lift_x;
					k_q     <= k_q + LVL_W'(1);
					state_q <= ST_B_LR;
				end
				ST_Q_RA: state_q <= ST_Q_RB;
				ST_Q_RB: begin
					da_q    <= dep_rdata;
					state_q <= ST_Q_CHK;
				end
				ST_Q_CHK: begin
					db_q <= dep_rdata;
					k_q  <= LVL_W'(LIFT_LEVELS - 1);
					if (da_q == DEPTH_NONE || dep_rdata == DEPTH_NONE) begin
						res_st_q <= STAT_UNVISITED;
						state_q  <= ST_RESP;
					end else begin
						if (da_q < dep_rdata) begin
							u_q  <= b_q;
							v_q  <= a_q;
							dv_q <= da_q;
						end else begin
							u_q  <= a_q;
							v_q  <= b_q;
							dv_q <= dep_rdata;
						end
						state_q <= ST_Q_LR;
					end
				end
				ST_Q_LR: state_q <= ST_Q_LD;
				ST_Q_LD: begin
					t_q     <= anc_rdata;
					state_q <= ST_Q_LC;
				end
				ST_Q_LC: begin
					if (dep_rdata >= dv_q)
						u_q <= t_q;
					if (k_q == '0) begin
						state_q <= ST_Q_SAME;
					end else begin
						k_q     <= k_q - LVL_W'(1);
						state_q <= ST_Q_LR;
					end
				end
				ST_Q_SAME: begin
					k_q <= LVL_W'(LIFT_LEVELS - 1);
					if (u_q == v_q) begin
						res_anc_q <= u_q;
						state_q   <= ST_Q_DL;
					end else begin
						state_q <= ST_Q_JU;
					end
				end
				ST_Q_JU: state_q <= ST_Q_JV;
				ST_Q_JV: begin
					au_q    <= anc_rdata;
					state_q <= ST_Q_JC;
				end
				ST_Q_JC: begin
					if (au_q != anc_rdata) begin
						u_q <= au_q;
						v_q <= anc_rdata;
					end
					if (k_q == '0) begin
						state_q <= ST_Q_PR;
					end else begin
						k_q     <= k_q - LVL_W'(1);
						state_q <= ST_Q_JU;
					end
				end
				ST_Q_PR: state_q <= ST_Q_PD;
				ST_Q_PD: begin
					res_anc_q <= anc_rdata;
					state_q   <= ST_Q_DL;
				end
				ST_Q_DL: state_q <= ST_Q_DW;
				ST_Q_DW: begin
					res_len_q <= LEN_W'((DEPTH_W + 1)'(da_q) + (DEPTH_W + 1)'(db_q)
						- ((DEPTH_W + 1)'(dep_rdata) << 1));
					state_q   <= ST_RESP;
				end
				default: state_q <= ST_IDLE;
			endcase
		end
	end

endmodule
`default_nettype wire

FILE: sv/lca_ram.sv
`default_nettype none
module lca_ram #(
	parameter int WIDTH = 8,
	parameter int DEPTH = 16
) (
	input  wire logic                     clk,
	input  wire logic                     we,
	input  wire logic [$clog2(DEPTH)-1:0] waddr,
	input  wire logic [WIDTH-1:0]         wdata,
	input  wire logic [$clog2(DEPTH)-1:0] raddr,
	output logic      [WIDTH-1:0]         rdata
);

	logic [WIDTH-1:0] mem [DEPTH];

	always_ff @(posedge clk) begin
		if (we)
			mem[waddr] <= wdata;
		rdata <= mem[raddr];
	end

endmodule
`default_nettype wire
